>>> rtl/bcnp_pkg.sv
// Shared definitions for the bounding-box corner nearest-point block.
// Holds default widths, corner geometry and the step control struct.
// No dependencies.
package bcnp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int NUM_CORNERS     = 4;

  // Corner order: (min row, min col), (min row, max col),
  // (max row, max col), (max row, min col). A set bit picks the box maximum.
  localparam logic [NUM_CORNERS-1:0] CORNER_MAX_ROW = 4'b1100;
  localparam logic [NUM_CORNERS-1:0] CORNER_MAX_COL = 4'b0110;

  typedef struct packed {
    logic go;     // the held request is applied to the state this cycle
    logic first;  // clear the state before applying the request
  } step_ctl_t;

endpackage

>>> rtl/bcnp_corner.sv
// Distance comparison for one box corner: flags when the new point is
// strictly nearer (Manhattan distance) than the stored point.
// Depends on nothing outside this file.
module bcnp_corner #(
  parameter int COORD_WIDTH = 16
) (
  input  logic signed [COORD_WIDTH-1:0] corner_row,
  input  logic signed [COORD_WIDTH-1:0] corner_col,
  input  logic signed [COORD_WIDTH-1:0] stored_row,
  input  logic signed [COORD_WIDTH-1:0] stored_col,
  input  logic signed [COORD_WIDTH-1:0] pt_row,
  input  logic signed [COORD_WIDTH-1:0] pt_col,
  output logic                          replace
);

  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic [COORD_WIDTH-1:0] a,
    input logic [COORD_WIDTH-1:0] b
  );
    logic [COORD_WIDTH:0] d;
    logic [COORD_WIDTH:0] nd;
    begin
      d  = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
      nd = -d;
      abs_diff = d[COORD_WIDTH] ? nd[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
    end
  endfunction

  logic [COORD_WIDTH:0] dist_old;
  logic [COORD_WIDTH:0] dist_new;

  always_comb begin
    dist_old = {1'b0, abs_diff(corner_row, stored_row)}
             + {1'b0, abs_diff(corner_col, stored_col)};
    dist_new = {1'b0, abs_diff(corner_row, pt_row)}
             + {1'b0, abs_diff(corner_col, pt_col)};
    replace  = dist_new < dist_old;
  end

endmodule

>>> rtl/bcnp_accum.sv
// Running state: bounding box, nearest point per corner and point count.
// Uses bcnp_pkg and four bcnp_corner comparators.
module bcnp_accum
  import bcnp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  step_ctl_t                     ctl,
  input  logic signed [COORD_WIDTH-1:0] pt_row,
  input  logic signed [COORD_WIDTH-1:0] pt_col,
  output logic signed [COORD_WIDTH-1:0] near_row_nxt [NUM_CORNERS],
  output logic signed [COORD_WIDTH-1:0] near_col_nxt [NUM_CORNERS],
  output logic        [COUNT_WIDTH-1:0] count_nxt
);

  localparam logic signed [COORD_WIDTH-1:0] COORD_TOP = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_BOT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COORD_WIDTH-1:0] box_min_row_r, box_min_col_r;
  logic signed [COORD_WIDTH-1:0] box_max_row_r, box_max_col_r;
  logic signed [COORD_WIDTH-1:0] near_row_r [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] near_col_r [NUM_CORNERS];
  logic        [COUNT_WIDTH-1:0] count_r;

  logic signed [COORD_WIDTH-1:0] box_min_row_nxt, box_min_col_nxt;
  logic signed [COORD_WIDTH-1:0] box_max_row_nxt, box_max_col_nxt;
  logic signed [COORD_WIDTH-1:0] base_min_row, base_min_col;
  logic signed [COORD_WIDTH-1:0] base_max_row, base_max_col;
  logic signed [COORD_WIDTH-1:0] base_row [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] base_col [NUM_CORNERS];
  logic        [COUNT_WIDTH-1:0] base_count;
  logic        [NUM_CORNERS-1:0] replace;

  // A first request starts from the reset values instead of the held state.
  always_comb begin
    base_min_row = ctl.first ? COORD_TOP : box_min_row_r;
    base_min_col = ctl.first ? COORD_TOP : box_min_col_r;
    base_max_row = ctl.first ? COORD_BOT : box_max_row_r;
    base_max_col = ctl.first ? COORD_BOT : box_max_col_r;
    base_count   = ctl.first ? '0 : count_r;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      base_row[i] = ctl.first ? COORD_TOP : near_row_r[i];
      base_col[i] = ctl.first ? COORD_TOP : near_col_r[i];
    end
    box_min_row_nxt = (pt_row < base_min_row) ? pt_row : base_min_row;
    box_min_col_nxt = (pt_col < base_min_col) ? pt_col : base_min_col;
    box_max_row_nxt = (pt_row > base_max_row) ? pt_row : base_max_row;
    box_max_col_nxt = (pt_col > base_max_col) ? pt_col : base_max_col;
    count_nxt       = base_count + COUNT_WIDTH'(1);
    for (int i = 0; i < NUM_CORNERS; i++) begin
      near_row_nxt[i] = replace[i] ? pt_row : base_row[i];
      near_col_nxt[i] = replace[i] ? pt_col : base_col[i];
    end
  end

  for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_corner
    bcnp_corner #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_corner (
      .corner_row (CORNER_MAX_ROW[g] ? box_max_row_nxt : box_min_row_nxt),
      .corner_col (CORNER_MAX_COL[g] ? box_max_col_nxt : box_min_col_nxt),
      .stored_row (base_row[g]),
      .stored_col (base_col[g]),
      .pt_row     (pt_row),
      .pt_col     (pt_col),
      .replace    (replace[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_row_r <= COORD_TOP;
      box_min_col_r <= COORD_TOP;
      box_max_row_r <= COORD_BOT;
      box_max_col_r <= COORD_BOT;
      count_r       <= '0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        near_row_r[i] <= COORD_TOP;
        near_col_r[i] <= COORD_TOP;
      end
    end else if (ctl.go) begin
      box_min_row_r <= box_min_row_nxt;
      box_min_col_r <= box_min_col_nxt;
      box_max_row_r <= box_max_row_nxt;
      box_max_col_r <= box_max_col_nxt;
      count_r       <= count_nxt;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        near_row_r[i] <= near_row_nxt[i];
        near_col_r[i] <= near_col_nxt[i];
      end
    end
  end

  // Once a point has been taken the box can never be inverted.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.go |=> (box_min_row_r <= box_max_row_r) && (box_min_col_r <= box_max_col_r))
    else $error("bounding box inverted after a point was taken");

  a_first_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.go && ctl.first |=> count_r == COUNT_WIDTH'(1))
    else $error("count not one after a clearing request");

endmodule

>>> rtl/bbox_corner_nearest_points_top.sv
// Top level of the bounding-box corner nearest-point block.
// Uses bcnp_pkg and bcnp_accum; holds the input and result registers.
//
// Usage:
//   Points of one region arrive on the in_ channel (valid/ready). A request
//   with in_first set clears the box, the corner points and the count before
//   the point is taken; a request with in_last set produces one result on the
//   out_ channel: the stored point nearest each box corner and the number of
//   points taken since the last clear. Requests without in_last produce none.
//   Path: an accepted point is held in the input register while it is
//   folded into the state; if it is a last point, its result is loaded into
//   the result register and shown on the out_ ports once that register is free.
//   Throughput: one point per cycle unless a last point stalls. The box
//   update and the four corner distance compares sit between the input
//   register and the state and result registers, so consecutive points
//   chain with no gap. If the receiver stalls with a result waiting,
//   points without in_last still flow; a last point waits in the input
//   register, and in_ready drops only while that register is occupied by it.
//   Synchronous reset (rst_n low) empties both registers and sets the state
//   to its start values: box min at the largest coordinate, box max at the
//   smallest, every corner point at the largest coordinate, count zero.
module bbox_corner_nearest_points_top
  import bcnp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_row,
  input  logic signed [COORD_WIDTH-1:0] in_col,
  input  logic                          in_first,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_c0_row,
  output logic signed [COORD_WIDTH-1:0] out_c0_col,
  output logic signed [COORD_WIDTH-1:0] out_c1_row,
  output logic signed [COORD_WIDTH-1:0] out_c1_col,
  output logic signed [COORD_WIDTH-1:0] out_c2_row,
  output logic signed [COORD_WIDTH-1:0] out_c2_col,
  output logic signed [COORD_WIDTH-1:0] out_c3_row,
  output logic signed [COORD_WIDTH-1:0] out_c3_col,
  output logic        [COUNT_WIDTH-1:0] out_points_taken
);

  logic                          s_valid_r;
  logic signed [COORD_WIDTH-1:0] s_row_r, s_col_r;
  logic                          s_first_r, s_last_r;

  logic                          out_valid_r;
  logic signed [COORD_WIDTH-1:0] res_row_r [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] res_col_r [NUM_CORNERS];
  logic        [COUNT_WIDTH-1:0] res_count_r;

  logic signed [COORD_WIDTH-1:0] near_row_nxt [NUM_CORNERS];
  logic signed [COORD_WIDTH-1:0] near_col_nxt [NUM_CORNERS];
  logic        [COUNT_WIDTH-1:0] count_nxt;

  logic      out_free;
  logic      out_load;
  logic      in_take;
  step_ctl_t ctl;

  // A held request may be applied unless it needs the result register and
  // that register is still occupied.
  always_comb begin
    out_free  = !out_valid_r || out_ready;
    ctl.go    = s_valid_r && (!s_last_r || out_free);
    ctl.first = s_first_r;
    out_load  = ctl.go && s_last_r;
    in_ready  = !s_valid_r || ctl.go;
    in_take   = in_valid && in_ready;
  end

  bcnp_accum #(
    .COORD_WIDTH (COORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .pt_row       (s_row_r),
    .pt_col       (s_col_r),
    .near_row_nxt (near_row_nxt),
    .near_col_nxt (near_col_nxt),
    .count_nxt    (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_row_r   <= in_row;
      s_col_r   <= in_col;
      s_first_r <= in_first;
      s_last_r  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_count_r <= count_nxt;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        res_row_r[i] <= near_row_nxt[i];
        res_col_r[i] <= near_col_nxt[i];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_c0_row       = res_row_r[0];
  assign out_c0_col       = res_col_r[0];
  assign out_c1_row       = res_row_r[1];
  assign out_c1_col       = res_col_r[1];
  assign out_c2_row       = res_row_r[2];
  assign out_c2_col       = res_col_r[2];
  assign out_c3_row       = res_row_r[3];
  assign out_c3_col       = res_col_r[3];
  assign out_points_taken = res_count_r;

  // A result is only loaded into a register that is free at that edge.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over an unread result");

  // A held last request that cannot go stays held with its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !ctl.go |=> s_valid_r && $stable(s_last_r) && $stable(s_row_r))
    else $error("held request lost while stalled");

endmodule
